FILE: src/rgb_led_crossfade_core_assert.svh
// Assertion macros shared by the crossfader RTL.
// Needs nothing; the using module supplies clock, reset and property.
`ifndef RGB_LED_CROSSFADE_CORE_ASSERT_SVH
`define RGB_LED_CROSSFADE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is low.
`define RGBXF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check, active during reset too.
`define RGBXF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGBXF_ASSERT(lbl, clk, rst_n, prop, msg)
`define RGBXF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: src/rgbxf_pkg.sv
// Shared types and constants of the RGB LED crossfader.
// No dependencies.
`default_nettype none

package rgbxf_pkg;

    localparam int LEVEL_W     = 8;    // one channel level
    localparam int CHAN_W      = 5;    // one packed colour field
    localparam int COLOR_W     = 15;   // packed 5-5-5 colour
    localparam int STEP_W      = 7;    // fade step count
    localparam int DIV_W       = 8;    // tick divider and step_divide
    localparam int ACC_W       = 15;   // |delta| * step, at most 255 * 127
    localparam int RECIP_SHIFT = 22;   // exact reciprocal for ACC_W bits, steps <= 127
    localparam int NUM_CHAN    = 3;

    localparam int FADE_STEPS_DEF = 100;

    localparam logic [DIV_W-1:0]   STEP_DIVIDE_RST = 8'd10;
    localparam logic [LEVEL_W-1:0] TARGET_RST      = 8'hFF;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Per-item fade control, from the timer to the channels.
    typedef struct packed {
        logic set;      // load a new target
        logic step;     // take one fade step
        logic finish;   // this step ends the fade
    } t_fade_ctl;

endpackage

`default_nettype wire

FILE: src/rgbxf_timer.sv
// Tick divider and fade step counter of the crossfader.
// Depends on rgbxf_pkg.
`default_nettype none

module rgbxf_timer #(
    parameter int FADE_STEPS = rgbxf_pkg::FADE_STEPS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_advance,
    input  wire logic                           i_command,
    input  wire logic [rgbxf_pkg::DIV_W-1:0]    i_step_divide,
    output rgbxf_pkg::t_fade_ctl                o_ctl
);

    localparam int DW1 = rgbxf_pkg::DIV_W + 1;
    localparam int SW1 = rgbxf_pkg::STEP_W + 1;
    localparam logic [SW1-1:0] STEPS_END = SW1'(FADE_STEPS);

    logic [rgbxf_pkg::DIV_W-1:0]  r_div;
    logic [rgbxf_pkg::DIV_W-1:0]  n_div;
    logic [rgbxf_pkg::STEP_W-1:0] r_step;
    logic [rgbxf_pkg::STEP_W-1:0] n_step;
    logic [DW1-1:0]               w_div_inc;
    logic [SW1-1:0]               w_step_inc;
    logic                         w_tick;

    assign w_tick     = i_advance && (i_command == rgbxf_pkg::CMD_TICK);
    assign w_div_inc  = {1'b0, r_div} + DW1'(1);
    assign w_step_inc = {1'b0, r_step} + SW1'(1);

    always_comb begin
        o_ctl.set    = i_advance && (i_command == rgbxf_pkg::CMD_SET);
        o_ctl.step   = w_tick && (w_div_inc >= {1'b0, i_step_divide});
        o_ctl.finish = o_ctl.step && (w_step_inc >= STEPS_END);
    end

    always_comb begin
        n_div  = r_div;
        n_step = r_step;
        if (o_ctl.set) begin
            n_step = '0;
        end else if (w_tick) begin
            if (o_ctl.step) begin
                n_div = '0;
                if (o_ctl.finish) begin
                    n_step = '0;
                end else begin
                    n_step = w_step_inc[rgbxf_pkg::STEP_W-1:0];
                end
            end else begin
                n_div = w_div_inc[rgbxf_pkg::DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div  <= '0;
            r_step <= '0;
        end else begin
            r_div  <= n_div;
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

FILE: src/rgbxf_channel.sv
// One colour channel of the crossfader: start, target, current level and
// the running |target - start| * step sum. Depends on rgbxf_pkg.
`default_nettype none

module rgbxf_channel #(
    parameter int FADE_STEPS = rgbxf_pkg::FADE_STEPS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire rgbxf_pkg::t_fade_ctl             i_ctl,
    input  wire logic [rgbxf_pkg::CHAN_W-1:0]     i_color,
    output logic      [rgbxf_pkg::LEVEL_W-1:0]    o_level,
    output logic      [rgbxf_pkg::CHAN_W-1:0]     o_target
);

    localparam int LW = rgbxf_pkg::LEVEL_W;
    localparam int AW = rgbxf_pkg::ACC_W;
    localparam int RS = rgbxf_pkg::RECIP_SHIFT;
    localparam int PW = AW + RS;
    // ceil(2^RS / FADE_STEPS): floor(x * RECIP / 2^RS) == floor(x / FADE_STEPS) for x < 2^AW
    localparam longint unsigned RECIP_INT =
        ((64'd1 << RS) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS);
    localparam logic [RS-1:0] RECIP = RS'(RECIP_INT);

    logic [LW-1:0] r_start,  n_start;
    logic [LW-1:0] r_target, n_target;
    logic [LW-1:0] r_cur,    n_cur;
    logic [AW-1:0] r_acc,    n_acc;
    logic [LW-1:0] r_absd,   n_absd;
    logic          r_neg,    n_neg;

    logic [LW-1:0] w_new_tgt;
    logic [LW:0]   w_diff;
    logic [AW-1:0] w_acc_sum;
    logic [PW-1:0] w_prod;
    logic [LW-1:0] w_quot;

    assign w_new_tgt = {i_color, {(LW - rgbxf_pkg::CHAN_W){1'b0}}};
    assign w_diff    = {1'b0, w_new_tgt} - {1'b0, r_cur};
    assign w_acc_sum = r_acc + AW'(r_absd);
    assign w_prod    = {{RS{1'b0}}, w_acc_sum} * {{AW{1'b0}}, RECIP};
    assign w_quot    = w_prod[RS +: LW];

    always_comb begin
        n_start  = r_start;
        n_target = r_target;
        n_cur    = r_cur;
        n_acc    = r_acc;
        n_absd   = r_absd;
        n_neg    = r_neg;
        priority if (i_ctl.set) begin
            // restart the fade from where the level is now
            n_start  = r_cur;
            n_target = w_new_tgt;
            n_acc    = '0;
            n_neg    = w_diff[LW];
            n_absd   = w_diff[LW] ? LW'(-w_diff) : w_diff[LW-1:0];
        end else if (i_ctl.finish) begin
            n_start = r_target;
            n_cur   = r_target;
            n_acc   = '0;
            n_absd  = '0;
            n_neg   = 1'b0;
        end else if (i_ctl.step) begin
            // truncation toward zero: offset the start by floor(|delta| * step / steps)
            n_acc = w_acc_sum;
            n_cur = r_neg ? (r_start - w_quot) : (r_start + w_quot);
        end else begin
            // hold the fade state between steps
            n_cur = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_target <= rgbxf_pkg::TARGET_RST;
            r_cur    <= '0;
            r_acc    <= '0;
            r_absd   <= rgbxf_pkg::TARGET_RST;
            r_neg    <= 1'b0;
        end else begin
            r_start  <= n_start;
            r_target <= n_target;
            r_cur    <= n_cur;
            r_acc    <= n_acc;
            r_absd   <= n_absd;
            r_neg    <= n_neg;
        end
    end

    assign o_level  = n_cur;
    assign o_target = n_target[LW-1 -: rgbxf_pkg::CHAN_W];

endmodule

`default_nettype wire

FILE: src/rgb_led_crossfade_core.sv
// Top level of the three-channel RGB LED crossfader.
// Depends on rgbxf_pkg, rgbxf_timer, rgbxf_channel, rgb_led_crossfade_core_assert.svh.
//
//  Channel   Direction  Width  Contents
//  s_axis    in         16+1   tdata: colour; tuser: command
//  m_axis    out        40     tdata: duties and target read-back
//  cfg       in         8      step_divide, write only
//
// One beat in per cycle and one beat out per cycle while the result is not
// stalled. An input register feeds the single update stage, which loads the
// result register. The recurrence on the channel state (add, reciprocal
// multiply, add) closes within that one update stage.
// Reset is synchronous, active low, and returns the valid flags, step_divide and channel state to their reset values.
// A stalled result holds the result register; the input register keeps taking
// a beat while the result register is free or drains in the same cycle.
`default_nettype none

module rgb_led_crossfade_core #(
    parameter int FADE_STEPS = rgbxf_pkg::FADE_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [14:0] color, [15] zero
    input  wire logic [0:0]  i_s_axis_tuser,   // [0] command

    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [7:0] duty_red, [15:8] duty_green,
                                               // [23:16] duty_blue, [38:24] target_readback,
                                               // [39] zero

    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);

`include "rgb_led_crossfade_core_assert.svh"

    localparam int LW = rgbxf_pkg::LEVEL_W;
    localparam int CW = rgbxf_pkg::CHAN_W;
    localparam int NC = rgbxf_pkg::NUM_CHAN;

    // step_divide register
    logic [rgbxf_pkg::DIV_W-1:0] r_step_divide;

    // input register
    logic                          r_in_valid;
    logic                          r_in_cmd;
    logic [rgbxf_pkg::COLOR_W-1:0] r_in_color;

    // result register
    logic        r_out_valid;
    logic [39:0] r_out_data;

    logic                 w_advance;
    rgbxf_pkg::t_fade_ctl w_ctl;
    logic [LW-1:0]        w_level  [NC];
    logic [CW-1:0]        w_target [NC];

    // Move a beat through the update stage when the result register is free
    // or is emptied in this cycle.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_divide <= rgbxf_pkg::STEP_DIVIDE_RST;
        end else if (i_cfg_we) begin
            r_step_divide <= i_cfg_wdata;
        end
    end

    // Hold the input beat until the update stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd   <= i_s_axis_tuser[0];
            r_in_color <= i_s_axis_tdata[rgbxf_pkg::COLOR_W-1:0];
        end
    end

    rgbxf_timer #(
        .FADE_STEPS (FADE_STEPS)
    ) u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_command     (r_in_cmd),
        .i_step_divide (r_step_divide),
        .o_ctl         (w_ctl)
    );

    for (genvar ch = 0; ch < NC; ch++) begin : g_chan
        rgbxf_channel #(
            .FADE_STEPS (FADE_STEPS)
        ) u_channel (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_color  (r_in_color[ch*CW +: CW]),
            .o_level  (w_level[ch]),
            .o_target (w_target[ch])
        );
    end

    // Drop the result beat once taken; load a new one on every update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Duties are inverted levels: 255 - level is the bitwise complement.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {1'b0, w_target[2], w_target[1], w_target[0],
                           ~w_level[2], ~w_level[1], ~w_level[0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `RGBXF_ASSERT(a_update_loads_result, i_clk, i_rst_n, w_advance |=> r_out_valid, "update did not load result")
    `RGBXF_ASSERT(a_input_held, i_clk, i_rst_n, r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_color), "pending input beat lost")
    `RGBXF_ASSERT(a_finish_is_step, i_clk, i_rst_n, w_ctl.finish |-> w_ctl.step, "fade finish without a step")
    `RGBXF_ASSERT(a_set_step_excl, i_clk, i_rst_n, !(w_ctl.set && w_ctl.step), "set and step in one update")
    `RGBXF_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

`default_nettype wire
